FILE: sv/vtf_pkg.sv
// Package with the types, constants and register map of the target follower.
`default_nettype none

package vtf_pkg;

  // Field widths.
  localparam int unsigned XW      = 9;   // image column
  localparam int unsigned AREAW   = 17;  // blob area
  localparam int unsigned CAREAW  = 15;  // centre area register
  localparam int unsigned GAINW   = 32;  // unsigned Q8.24 gain
  localparam int unsigned LIMW    = 15;  // forward limit register
  localparam int unsigned FWDW    = 16;  // forward drive
  localparam int unsigned TURNW   = 18;  // turn drive

  // Internal error and state widths.
  localparam int unsigned XERRW   = 10;  // column error
  localparam int unsigned DXW     = 11;  // column error change
  localparam int unsigned INTW    = 11;  // turn integral
  localparam int unsigned AERRW   = 17;  // area error
  localparam int unsigned DAW     = 18;  // area error change
  localparam int unsigned CAPW    = 16;  // area cap, twice the centre area

  // Scaled product widths: full product minus the 16 dropped fraction bits.
  localparam int unsigned FRAC    = 16;
  localparam int unsigned FPW     = GAINW + 1 + AERRW - FRAC;
  localparam int unsigned FDW     = GAINW + 1 + DAW - FRAC;
  localparam int unsigned TPW     = GAINW + 1 + XERRW - FRAC;
  localparam int unsigned TIW     = GAINW + 1 + INTW - FRAC;
  localparam int unsigned TDW     = GAINW + 1 + DXW - FRAC;
  localparam int unsigned FSUMW   = FDW + 1;
  localparam int unsigned TSUMW   = TIW + 2;

  // Control constants.
  localparam logic signed [INTW-1:0]  IntLimit = 11'sd700;
  localparam logic signed [AERRW-1:0] DzHigh   = 17'sd1500;
  localparam logic signed [AERRW-1:0] DzLow    = -17'sd4000;

  // Register map.
  typedef enum logic [2:0] {
    REG_CENTRE_X      = 3'd0,
    REG_CENTRE_AREA   = 3'd1,
    REG_FORWARD_KP    = 3'd2,
    REG_FORWARD_KD    = 3'd3,
    REG_TURN_KP       = 3'd4,
    REG_TURN_KI       = 3'd5,
    REG_TURN_KD       = 3'd6,
    REG_FORWARD_LIMIT = 3'd7
  } reg_idx_e;

  // Register reset values.
  localparam logic [XW-1:0]     CentreXRst      = 9'd160;
  localparam logic [CAREAW-1:0] CentreAreaRst   = 15'd6500;
  localparam logic [GAINW-1:0]  ForwardKpRst    = 32'd16777;
  localparam logic [GAINW-1:0]  ForwardKdRst    = 32'd8389;
  localparam logic [GAINW-1:0]  TurnKpRst       = 32'd36071014;
  localparam logic [GAINW-1:0]  TurnKiRst       = 32'd1678;
  localparam logic [GAINW-1:0]  TurnKdRst       = 32'd3355443;
  localparam logic [LIMW-1:0]   ForwardLimitRst = 15'd7680;

  // Configuration register set.
  typedef struct packed {
    logic [XW-1:0]     centre_x;
    logic [CAREAW-1:0] centre_area;
    logic [GAINW-1:0]  forward_kp;
    logic [GAINW-1:0]  forward_kd;
    logic [GAINW-1:0]  turn_kp;
    logic [GAINW-1:0]  turn_ki;
    logic [GAINW-1:0]  turn_kd;
    logic [LIMW-1:0]   forward_limit;
  } cfg_t;

  // Error stage contents.
  typedef struct packed {
    logic                    seen;
    logic                    fwd_active;
    logic signed [AERRW-1:0] area_err;
    logic signed [DAW-1:0]   darea;
    logic signed [XERRW-1:0] x_err;
    logic signed [DXW-1:0]   dx;
    logic signed [INTW-1:0]  integ;
  } err_t;

  // Product stage contents, already floored to Q.8.
  typedef struct packed {
    logic                  seen;
    logic                  fwd_active;
    logic signed [FPW-1:0] fp;
    logic signed [FDW-1:0] fd;
    logic signed [TPW-1:0] tp;
    logic signed [TIW-1:0] ti;
    logic signed [TDW-1:0] td;
  } prod_t;

endpackage

`default_nettype wire

FILE: sv/vtf_prep.sv
// Error stage: computes errors, updates controller state, registers the errors.
`default_nettype none

module vtf_prep import vtf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             accept_i,
  input  wire logic [XW-1:0]    object_x_i,
  input  wire logic [AREAW-1:0] object_area_i,
  input  wire logic             motor_off_i,
  output err_t                  err_o
);

  logic signed [AERRW-1:0] last_area_q, last_area_d;
  logic signed [XERRW-1:0] last_x_q, last_x_d;
  logic signed [INTW-1:0]  integ_q, integ_d;
  err_t                    err_q, err_d;

  logic [CAPW-1:0]         cap;
  logic [CAPW-1:0]         area_cap;
  logic signed [INTW:0]    isum;
  logic signed [INTW-1:0]  isat;

  // Errors against the set point, with the area capped at twice the centre area.
  always_comb begin
    cap      = {cfg_i.centre_area, 1'b0};
    area_cap = (object_area_i > {1'b0, cap}) ? cap : object_area_i[CAPW-1:0];

    err_d.seen     = (object_area_i != '0);
    err_d.x_err    = $signed({1'b0, cfg_i.centre_x}) - $signed({1'b0, object_x_i});
    err_d.area_err = $signed({2'b00, cfg_i.centre_area}) - $signed({1'b0, area_cap});
    err_d.darea    = DAW'(err_d.area_err) - DAW'(last_area_q);
    err_d.dx       = DXW'(err_d.x_err) - DXW'(last_x_q);
    err_d.fwd_active = (err_d.area_err > DzHigh) || (err_d.area_err < DzLow);

    // Integral adds the error and is clamped.
    isum = (INTW+1)'(integ_q) + (INTW+1)'(err_d.x_err);
    if (isum > (INTW+1)'(IntLimit)) begin
      isat = IntLimit;
    end else if (isum < -(INTW+1)'(IntLimit)) begin
      isat = -IntLimit;
    end else begin
      isat = isum[INTW-1:0];
    end
    err_d.integ = isat;
  end

  // State follows each seen target; a motor-off request clears the integral.
  always_comb begin
    last_area_d = last_area_q;
    last_x_d    = last_x_q;
    integ_d     = integ_q;
    if (accept_i && err_d.seen) begin
      last_x_d = err_d.x_err;
      integ_d  = motor_off_i ? '0 : isat;
      if (err_d.fwd_active) begin
        last_area_d = err_d.area_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_area_q <= '0;
      last_x_q    <= '0;
      integ_q     <= '0;
    end else begin
      last_area_q <= last_area_d;
      last_x_q    <= last_x_d;
      integ_q     <= integ_d;
    end
  end

  // Error register loads with each accepted request.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

`default_nettype wire

FILE: sv/vtf_mul.sv
// Product stage: five gain-by-error products, floored to Q.8 and registered.
`default_nettype none

module vtf_mul import vtf_pkg::*; (
  input  wire logic clk_i,
  input  wire cfg_t cfg_i,
  input  wire logic load_i,
  input  wire err_t err_i,
  output prod_t     prod_o
);

  logic signed [FPW+FRAC-1:0] fp_full;
  logic signed [FDW+FRAC-1:0] fd_full;
  logic signed [TPW+FRAC-1:0] tp_full;
  logic signed [TIW+FRAC-1:0] ti_full;
  logic signed [TDW+FRAC-1:0] td_full;
  prod_t                      prod_q, prod_d;

  // Signed products; dropping the low bits floors toward minus infinity.
  always_comb begin
    fp_full = $signed({1'b0, cfg_i.forward_kp}) * err_i.area_err;
    fd_full = $signed({1'b0, cfg_i.forward_kd}) * err_i.darea;
    tp_full = $signed({1'b0, cfg_i.turn_kp}) * err_i.x_err;
    ti_full = $signed({1'b0, cfg_i.turn_ki}) * err_i.integ;
    td_full = $signed({1'b0, cfg_i.turn_kd}) * err_i.dx;

    prod_d.seen       = err_i.seen;
    prod_d.fwd_active = err_i.fwd_active;
    prod_d.fp         = fp_full[FPW+FRAC-1:FRAC];
    prod_d.fd         = fd_full[FDW+FRAC-1:FRAC];
    prod_d.tp         = tp_full[TPW+FRAC-1:FRAC];
    prod_d.ti         = ti_full[TIW+FRAC-1:FRAC];
    prod_d.td         = td_full[TDW+FRAC-1:FRAC];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: sv/vtf_out.sv
// Result stage: sums the terms, clamps both drives and registers the result.
`default_nettype none

module vtf_out import vtf_pkg::*; (
  input  wire logic              clk_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              load_i,
  input  wire prod_t             prod_i,
  output logic signed [FWDW-1:0] forward_drive_o,
  output logic signed [TURNW-1:0] turn_drive_o,
  output logic                   target_seen_o
);

  logic signed [FSUMW-1:0]  fsum;
  logic signed [FSUMW-1:0]  flim;
  logic signed [TSUMW-1:0]  tsum;
  logic signed [TSUMW:0]    tneg;
  logic signed [FWDW-1:0]   fwd_q, fwd_d;
  logic signed [TURNW-1:0]  turn_q, turn_d;
  logic                     seen_q;

  // Forward PD term, zero with no target or inside the dead zone, clamped to the limit.
  always_comb begin
    fsum = FSUMW'(prod_i.fp) + FSUMW'(prod_i.fd);
    flim = $signed({{(FSUMW-LIMW){1'b0}}, cfg_i.forward_limit});
    if (!prod_i.seen || !prod_i.fwd_active) begin
      fwd_d = '0;
    end else if (fsum > flim) begin
      fwd_d = FWDW'(flim);
    end else if (fsum < -flim) begin
      fwd_d = FWDW'(-flim);
    end else begin
      fwd_d = fsum[FWDW-1:0];
    end
  end

  // Negated PID turn term, zero with no target, saturated to the drive range.
  always_comb begin
    tsum = TSUMW'(prod_i.tp) + TSUMW'(prod_i.ti) + TSUMW'(prod_i.td);
    tneg = -((TSUMW+1)'(tsum));
    if (!prod_i.seen) begin
      turn_d = '0;
    end else if (tneg > $signed((TSUMW+1)'({1'b0, {(TURNW-1){1'b1}}}))) begin
      turn_d = {1'b0, {(TURNW-1){1'b1}}};
    end else if (tneg < -$signed((TSUMW+1)'({1'b1, {(TURNW-1){1'b0}}}))) begin
      turn_d = {1'b1, {(TURNW-1){1'b0}}};
    end else begin
      turn_d = tneg[TURNW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fwd_q  <= fwd_d;
      turn_q <= turn_d;
      seen_q <= prod_i.seen;
    end
  end

  assign forward_drive_o = fwd_q;
  assign turn_drive_o    = turn_q;
  assign target_seen_o   = seen_q;

endmodule

`default_nettype wire

FILE: sv/visual_target_follow_pid_core.sv
// Top level of the camera target follower: handshakes, registers and pipeline.
//
// Usage: each camera report is one request on the input channel (in_valid_i,
// in_stall_o) with object_x_i, object_area_i and motor_off_i. Each request
// gives exactly one result on the output channel (out_valid_o, out_stall_i)
// with forward_drive_o, turn_drive_o (signed Q.8) and target_seen_o.
// The block is a three-stage pipeline: error register, product register and
// result register. An accepted request moves from the error register through
// the product register into the result register, where its result is offered.
// One request enters per cycle while in_stall_o is low; the controller
// state updates as each request enters, so back-to-back requests see each
// other's state. Each stage holds while the stage after it is full and
// stalled, so the input stalls only when all three stages are full.
// Configuration writes (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// are always taken and are meant for times when the pipeline is empty.
// Reset clears the pipeline, the controller state and sets every register to
// its default value.
`default_nettype none

module visual_target_follow_pid_core import vtf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [GAINW-1:0]  cfg_data_i,
  // Camera report channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [XW-1:0]     object_x_i,
  input  wire logic [AREAW-1:0]  object_area_i,
  input  wire logic              motor_off_i,
  // Drive result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic signed [FWDW-1:0] forward_drive_o,
  output logic signed [TURNW-1:0] turn_drive_o,
  output logic                   target_seen_o
);

  cfg_t  cfg_q, cfg_d;
  err_t  err;
  prod_t prod;
  logic  v1_q, v2_q, v3_q;
  logic  ready1, ready2, ready3;
  logic  accept;

  // Configuration register writes.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CENTRE_X:      cfg_d.centre_x      = cfg_data_i[XW-1:0];
        REG_CENTRE_AREA:   cfg_d.centre_area   = cfg_data_i[CAREAW-1:0];
        REG_FORWARD_KP:    cfg_d.forward_kp    = cfg_data_i;
        REG_FORWARD_KD:    cfg_d.forward_kd    = cfg_data_i;
        REG_TURN_KP:       cfg_d.turn_kp       = cfg_data_i;
        REG_TURN_KI:       cfg_d.turn_ki       = cfg_data_i;
        REG_TURN_KD:       cfg_d.turn_kd       = cfg_data_i;
        REG_FORWARD_LIMIT: cfg_d.forward_limit = cfg_data_i[LIMW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centre_x      <= CentreXRst;
      cfg_q.centre_area   <= CentreAreaRst;
      cfg_q.forward_kp    <= ForwardKpRst;
      cfg_q.forward_kd    <= ForwardKdRst;
      cfg_q.turn_kp       <= TurnKpRst;
      cfg_q.turn_ki       <= TurnKiRst;
      cfg_q.turn_kd       <= TurnKdRst;
      cfg_q.forward_limit <= ForwardLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Per-stage flow control: a stage loads when it is empty or drains.
  assign ready3     = !v3_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept     = in_valid_i && ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign out_valid_o = v3_q;

  vtf_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .object_x_i    (object_x_i),
    .object_area_i (object_area_i),
    .motor_off_i   (motor_off_i),
    .err_o         (err)
  );

  vtf_mul u_mul (
    .clk_i  (clk_i),
    .cfg_i  (cfg_q),
    .load_i (v1_q && ready2),
    .err_i  (err),
    .prod_o (prod)
  );

  vtf_out u_out (
    .clk_i           (clk_i),
    .cfg_i           (cfg_q),
    .load_i          (v2_q && ready3),
    .prod_i          (prod),
    .forward_drive_o (forward_drive_o),
    .turn_drive_o    (turn_drive_o),
    .target_seen_o   (target_seen_o)
  );

  // A result without a target carries zero drives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !target_seen_o |-> forward_drive_o == '0 && turn_drive_o == '0)
    else $error("unseen target result has nonzero drive");

  // The input stalls only when every stage is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q)
    else $error("input stalled with a free pipeline stage");

  // A request leaving the error stage lands in the product stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && ready2 |=> v2_q)
    else $error("request lost between error and product stages");

  // A request leaving the product stage lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && ready3 |=> v3_q)
    else $error("request lost between product and result stages");

endmodule

`default_nettype wire
